// ===== rtl/byte_frequency_sorted_table_macros.svh =====
// Assertion macros shared by the byte frequency table RTL.
`ifndef BYTE_FREQUENCY_SORTED_TABLE_MACROS_SVH
`define BYTE_FREQUENCY_SORTED_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising edge once reset is released.
`define BFST_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bfst: assertion failed");

// Checks that a condition implies another one in the same cycle.
`define BFST_ASSERT_IMPLY(name, clk, rstn, cond, conseq) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
    else $error("bfst: implication failed");

`else

`define BFST_ASSERT(name, clk, rstn, prop)
`define BFST_ASSERT_IMPLY(name, clk, rstn, cond, conseq)

`endif

`endif

// ===== rtl/bfst_pkg.sv =====
// Types and constants of the byte frequency sorted table.
`default_nettype none

package bfst_pkg;

  // Operation codes carried in the kind field.
  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  // Percentage format: 100 scaled by 2^8, quotient fits in 15 bits.
  localparam int          PCT_W    = 15;
  localparam logic [14:0] PCT_MAX  = 15'd25600;
  localparam int          RANK_W   = 8;
  localparam int          OUT_CNT_W = 32;

  typedef struct packed {
    logic       kind;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [7:0]            entry_symbol;
    logic [OUT_CNT_W-1:0]  entry_count;
    logic [PCT_W-1:0]      entry_percent;
    logic                  final_entry;
    logic                  table_empty;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SCAN,
    ST_DIV,
    ST_PUSH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/bfst_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module bfst_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bfst_div.sv =====
// Serial restoring divider that forms count * 25600 / total, one bit a cycle.
`default_nettype none

module bfst_div
  import bfst_pkg::*;
#(
  parameter int CntW = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CntW-1:0]  cnt_i,
  input  wire logic [CntW-1:0]  total_i,
  output logic                  done_o,
  output logic [PCT_W-1:0]      quot_o
);

  localparam int NumW  = CntW + PCT_W;
  localparam int StepW = $clog2(PCT_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [PCT_W-1:0]  num_q, num_d;
  logic [PCT_W-1:0]  quot_q, quot_d;
  logic [CntW-1:0]   tot_q, tot_d;
  logic [NumW-1:0]   num_full;
  logic [CntW:0]     trial;
  logic [CntW:0]     diff;

  // 25600 is 1024 * (16 + 8 + 1), so the scaled count is three shifted copies.
  assign num_full = (NumW'(cnt_i) << 14) + (NumW'(cnt_i) << 13) + (NumW'(cnt_i) << 10);

  assign trial = {rem_q, num_q[PCT_W-1]};
  assign diff  = trial - {1'b0, tot_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    tot_d  = tot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(PCT_W);
      rem_d  = num_full[NumW-1:PCT_W];
      num_d  = num_full[PCT_W-1:0];
      quot_d = '0;
      tot_d  = total_i;
    end else if (busy_q) begin
      num_d = {num_q[PCT_W-2:0], 1'b0};
      if (!diff[CntW]) begin
        rem_d  = diff[CntW-1:0];
        quot_d = {quot_q[PCT_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[CntW-1:0];
        quot_d = {quot_q[PCT_W-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    tot_q  <= tot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/byte_frequency_sorted_table.sv =====
// Top level of the byte frequency table sorted by count.
//
//   Channel  Direction  Signals                          Beat
//   in       sink       in_valid_i in_ready_o in_data_i  add a byte or fetch an entry
//   out      source     out_valid_o out_ready_i out_data_o one sorted entry per fetch
//
// Between accepted beats an add reads the count, then writes it back; a fetch on an empty
// table goes straight to the output slot; any other fetch scans every entry with one RAM
// read a cycle, finishes the compare, runs the divider and loads the output slot when free.
// Reset clears the counts through the per-entry presence flags, without a clearing pass.
// Emitted flags sit in a second RAM: a scan that opens a new pass writes them to zero.
// A stalled output holds one finished entry; adds keep flowing while it waits.
`default_nettype none

`include "byte_frequency_sorted_table_macros.svh"

module byte_frequency_sorted_table
  import bfst_pkg::*;
#(
  parameter int ALPHABET_SIZE = 256,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int AW   = $clog2(ALPHABET_SIZE);
  localparam int RamW = COUNT_BITS + RANK_W;
  localparam logic [AW:0] ScanEnd = (AW + 1)'(ALPHABET_SIZE);
  localparam logic [8:0]  SymLim  = 9'(ALPHABET_SIZE);

  state_e state_q, state_d;

  // Presence flags stand in for the cleared count store: an absent symbol reads as zero.
  logic [ALPHABET_SIZE-1:0] present_q, present_d;
  logic [COUNT_BITS-1:0]    total_q, total_d;
  logic [8:0]               distinct_q, distinct_d;
  logic [8:0]               fetched_q, fetched_d;
  logic                     drain_q, drain_d;
  // Set for a scan that opens a new pass; stored emitted flags are ignored and cleared.
  logic                     restart_q, restart_d;

  // Scan bookkeeping.
  logic [AW:0]              issue_q, issue_d;
  logic                     cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]            cmp_idx_q, cmp_idx_d;
  logic                     found_q, found_d;
  logic [COUNT_BITS-1:0]    best_cnt_q, best_cnt_d;
  logic [RANK_W-1:0]        best_rank_q, best_rank_d;
  logic [AW-1:0]            best_idx_q, best_idx_d;
  logic                     fin_q, fin_d;

  logic [AW-1:0]            sym_q, sym_d;
  out_t                     res_q, res_d;
  out_t                     out_q, out_d;
  logic                     out_vld_q, out_vld_d;
  logic                     out_load;

  // Count memory port.
  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [RamW-1:0]          ram_wdata;
  logic [RamW-1:0]          ram_rdata;
  logic [COUNT_BITS-1:0]    rd_cnt;
  logic [RANK_W-1:0]        rd_rank;

  // Emitted flag memory port.
  logic                     emit_we;
  logic [AW-1:0]            emit_addr;
  logic                     emit_wdata;
  logic                     emit_rdata;
  logic                     emit_rd;

  // Divider.
  logic                     div_start;
  logic                     div_done;
  logic [PCT_W-1:0]         div_quot;
  logic [OUT_CNT_W-1:0]     best_cnt_out;

  // Intermediate values of the add and scan paths.
  logic [COUNT_BITS-1:0]    old_cnt;
  logic [COUNT_BITS-1:0]    new_cnt;
  logic [RANK_W-1:0]        new_rank;
  logic                     eligible;
  logic                     better;
  logic [8:0]               fetched_inc;

  bfst_ram #(
    .Width (RamW),
    .Depth (ALPHABET_SIZE)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign rd_rank = ram_rdata[RamW-1:COUNT_BITS];
  assign rd_cnt  = ram_rdata[COUNT_BITS-1:0];

  bfst_ram #(
    .Width (1),
    .Depth (ALPHABET_SIZE)
  ) u_emit_ram (
    .clk_i   (clk_i),
    .we_i    (emit_we),
    .addr_i  (emit_addr),
    .wdata_i (emit_wdata),
    .rdata_o (emit_rdata)
  );

  // A scan that opens a new pass treats every entry as not yet emitted.
  assign emit_rd = emit_rdata & ~restart_q;

  bfst_div #(
    .CntW (COUNT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cnt_i   (best_cnt_q),
    .total_i (total_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // The result port is 32 bits wide; wider counts saturate to all ones.
  if (COUNT_BITS > OUT_CNT_W) begin : g_cnt_sat
    assign best_cnt_out = (|best_cnt_q[COUNT_BITS-1:OUT_CNT_W]) ? '1 :
                          best_cnt_q[OUT_CNT_W-1:0];
  end else begin : g_cnt_ext
    assign best_cnt_out = OUT_CNT_W'(best_cnt_q);
  end

  // Read-modify-write of one count: a symbol seen for the first time gets the next rank.
  assign old_cnt  = present_q[sym_q] ? rd_cnt : '0;
  assign new_cnt  = (&old_cnt) ? old_cnt : old_cnt + COUNT_BITS'(1);
  assign new_rank = present_q[sym_q] ? rd_rank : distinct_q[RANK_W-1:0];

  // Smallest count wins; equal counts go to the earlier first appearance.
  assign eligible = present_q[cmp_idx_q] & ~emit_rd;
  assign better   = !found_q || (rd_cnt < best_cnt_q) ||
                    ((rd_cnt == best_cnt_q) && (rd_rank < best_rank_q));
  assign fetched_inc = fetched_q + 9'd1;

  always_comb begin
    state_d     = state_q;
    present_d   = present_q;
    total_d     = total_q;
    distinct_d  = distinct_q;
    fetched_d   = fetched_q;
    drain_d     = drain_q;
    restart_d   = restart_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    best_cnt_d  = best_cnt_q;
    best_rank_d = best_rank_q;
    best_idx_d  = best_idx_q;
    fin_d       = fin_q;
    sym_d       = sym_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_addr    = in_data_i.symbol[AW-1:0];
    ram_wdata   = {new_rank, new_cnt};
    emit_we     = 1'b0;
    emit_addr   = sym_q;
    emit_wdata  = 1'b0;
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_ADD) begin
            // The first add after a full drain starts a fresh table.
            if (drain_q) begin
              present_d  = '0;
              total_d    = '0;
              distinct_d = '0;
              fetched_d  = '0;
              drain_d    = 1'b0;
            end
            sym_d = in_data_i.symbol[AW-1:0];
            if ({1'b0, in_data_i.symbol} < SymLim) begin
              state_d = ST_ADD_WR;
            end
          end else if (distinct_q == 9'd0) begin
            res_d             = '0;
            res_d.table_empty = 1'b1;
            state_d           = ST_PUSH;
          end else begin
            // A fetch after the last entry starts another pass over the same table.
            if (drain_q || (fetched_q >= distinct_q)) begin
              restart_d = 1'b1;
              fetched_d = '0;
              drain_d   = 1'b0;
            end else begin
              restart_d = 1'b0;
            end
            issue_d = '0;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_ADD_WR: begin
        ram_we           = 1'b1;
        ram_addr         = sym_q;
        present_d[sym_q] = 1'b1;
        if (!present_q[sym_q]) begin
          // A newly present symbol has not been emitted in this pass.
          emit_we    = 1'b1;
          distinct_d = distinct_q + 9'd1;
        end
        if (!(&total_q)) begin
          total_d = total_q + COUNT_BITS'(1);
        end
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if (issue_q < ScanEnd) begin
          ram_addr  = issue_q[AW-1:0];
          emit_addr = issue_q[AW-1:0];
          emit_we   = restart_q;
          issue_d   = issue_q + (AW + 1)'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[AW-1:0];
        end
        if (cmp_vld_q && eligible && better) begin
          found_d     = 1'b1;
          best_cnt_d  = rd_cnt;
          best_rank_d = rd_rank;
          best_idx_d  = cmp_idx_q;
        end
        if ((issue_q == ScanEnd) && !cmp_vld_q) begin
          if (!found_q) begin
            res_d             = '0;
            res_d.table_empty = 1'b1;
            state_d           = ST_PUSH;
          end else begin
            emit_we    = 1'b1;
            emit_addr  = best_idx_q;
            emit_wdata = 1'b1;
            fetched_d  = fetched_inc;
            fin_d      = (fetched_inc >= distinct_q);
            drain_d    = (fetched_inc >= distinct_q);
            div_start  = 1'b1;
            state_d    = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          res_d.entry_symbol  = 8'(best_idx_q);
          res_d.entry_count   = best_cnt_out;
          res_d.entry_percent = (div_quot > PCT_MAX) ? PCT_MAX : div_quot;
          res_d.final_entry   = fin_q;
          res_d.table_empty   = 1'b0;
          state_d             = ST_PUSH;
        end
      end

      ST_PUSH: begin
        // Wait for the output slot; the previous entry may still be stalled there.
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_vld_d = (out_vld_q & ~out_ready_i) | out_load;
  assign out_d     = out_load ? res_q : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      present_q  <= '0;
      total_q    <= '0;
      distinct_q <= '0;
      fetched_q  <= '0;
      drain_q    <= 1'b0;
      restart_q  <= 1'b0;
      issue_q    <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      present_q  <= present_d;
      total_q    <= total_d;
      distinct_q <= distinct_d;
      fetched_q  <= fetched_d;
      drain_q    <= drain_d;
      restart_q  <= restart_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    best_cnt_q  <= best_cnt_d;
    best_rank_q <= best_rank_d;
    best_idx_q  <= best_idx_d;
    fin_q       <= fin_d;
    sym_q       <= sym_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Every present symbol holds exactly one rank, and a pass never fetches more than that.
  `BFST_ASSERT(a_distinct_matches, clk_i, rst_ni, $countones(present_q) == int'(distinct_q))
  `BFST_ASSERT(a_fetched_bound, clk_i, rst_ni, fetched_q <= distinct_q)
  `BFST_ASSERT_IMPLY(a_drain_full, clk_i, rst_ni, drain_q, fetched_q == distinct_q)
  `BFST_ASSERT_IMPLY(a_div_in_state, clk_i, rst_ni, div_done, state_q == ST_DIV)

endmodule

`default_nettype wire
